>>> design/assert_macros.svh
// Assertion macros shared by the bitmap frame allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bitmap frame allocator: assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BFA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bitmap frame allocator: assertion failed");

`endif

>>> design/bfa_pkg.sv
// Shared types and constants of the bitmap frame allocator.
`default_nettype none
package bfa_pkg;
    localparam int OPC_W  = 3;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 16;
    localparam int KB_W   = 18;
    localparam int WORD_W = 32;
    localparam int NIB_W  = 4;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [KB_W-1:0] KB_RESET = 18'h20000;

    localparam logic [OPC_W-1:0] OP_INIT    = 3'd0;
    localparam logic [OPC_W-1:0] OP_ALLOC   = 3'd1;
    localparam logic [OPC_W-1:0] OP_FREE    = 3'd2;
    localparam logic [OPC_W-1:0] OP_RELEASE = 3'd3;
    localparam logic [OPC_W-1:0] OP_RESERVE = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_ROOM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO    = 2'd2;

    localparam logic REG_MEMORY_KB = 1'b0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SRD,
        ST_SSCAN,
        ST_MSET,
        ST_MCNT,
        ST_MRD,
        ST_MWR,
        ST_ZRD,
        ST_ZWR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

    typedef struct packed {
        logic found;
        logic past_end;
    } t_scan_res;
endpackage
`default_nettype wire

>>> design/bfa_req_if.sv
// Request channel of the bitmap frame allocator.
`default_nettype none
interface bfa_req_if;
    logic                        valid;
    logic                        ready;
    logic [bfa_pkg::OPC_W-1:0]   opcode;
    logic [bfa_pkg::ADDR_W-1:0]  address;
    logic [bfa_pkg::LEN_W-1:0]   length;

    modport source (output valid, opcode, address, length, input ready);
    modport sink (input valid, opcode, address, length, output ready);
endinterface
`default_nettype wire

>>> design/bfa_rsp_if.sv
// Result channel of the bitmap frame allocator.
`default_nettype none
interface bfa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bfa_pkg::STAT_W-1:0]  status;
    logic [bfa_pkg::ADDR_W-1:0]  frame_address;
    logic [bfa_pkg::CNT_W-1:0]   free_frames;
    logic [bfa_pkg::CNT_W-1:0]   used_frames;

    modport source (output valid, status, frame_address, free_frames, used_frames,
                    input ready);
    modport sink (input valid, status, frame_address, free_frames, used_frames,
                  output ready);
endinterface
`default_nettype wire

>>> design/bitmap_frame_allocator.sv
// Bitmap physical frame allocator, first fit, top level.
// Requests arrive on i_req (opcode, address, length) and are taken when the
// block is idle; each request gives exactly one result on o_rsp (status,
// frame_address, free_frames, used_frames), held in an output register until
// taken. One request is in work at a time.
// Init sweeps the bitmap and marks every frame used.
// Free, release and reserve compute the frame range, then read and write
// back each bitmap word touched; release and reserve then set frame zero
// used if the frame count is not zero. Alloc reads the bitmap word by word
// and checks four frames a cycle, pausing for each word read, then runs the
// marking pass. Each word update is a read-modify-write of the one port.
// After reset the block runs a clearing pass over the bitmap that marks
// every frame used; no request is taken meanwhile,
// while memory_kb writes on the APB port are taken at any time.
// When the receiver stalls, a finished result waits in the output register;
// the next request is still taken, and its result waits until that one has gone.
`default_nettype none
`include "assert_macros.svh"
module bitmap_frame_allocator #(
    parameter int MAX_FRAMES  = 32768,
    parameter int FRAME_BYTES = 4096
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    bfa_req_if.sink                          i_req,
    bfa_rsp_if.source                        o_rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bfa_pkg::APB_AW-1:0]  paddr,
    input  wire logic [bfa_pkg::APB_DW-1:0]  pwdata,
    output logic [bfa_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);
    localparam int WORDS  = (MAX_FRAMES + 31) / 32;
    localparam int WA_W   = $clog2(WORDS);
    localparam int FR_W   = WA_W + 5;
    localparam int FC_W   = $clog2(MAX_FRAMES + 1);
    localparam int FB_LOG = $clog2(FRAME_BYTES);
    localparam int KB_SH  = FB_LOG - 9;
    localparam int RESET_RAW = (131072 * 2) >> KB_SH;
    localparam int RESET_FC  = (RESET_RAW > MAX_FRAMES) ? MAX_FRAMES : RESET_RAW;
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);

    bfa_pkg::t_state r_state, n_state;

    logic [bfa_pkg::KB_W-1:0]   r_kb;
    logic [FC_W-1:0]            r_used, n_used;
    logic [bfa_pkg::OPC_W-1:0]  r_op;
    logic [bfa_pkg::ADDR_W-1:0] r_addr;
    logic [bfa_pkg::LEN_W-1:0]  r_len;
    logic [WA_W-1:0]            r_widx, n_widx;
    logic [WA_W-1:0]            r_wfirst, n_wfirst;
    logic [WA_W-1:0]            r_wlast, n_wlast;
    logic [2:0]                 r_nib, n_nib;
    logic [31:0]                r_ms, n_ms;
    logic [31:0]                r_mcount, n_mcount;
    logic [FC_W-1:0]            r_me, n_me;
    logic [4:0]                 r_mlo, n_mlo;
    logic [4:0]                 r_mhi, n_mhi;
    logic                       r_mval, n_mval;
    logic [bfa_pkg::STAT_W-1:0] r_status, n_status;
    logic [bfa_pkg::ADDR_W-1:0] r_faddr, n_faddr;
    logic                       r_resp, n_resp;
    logic                       r_ovalid, n_ovalid;
    logic [bfa_pkg::STAT_W-1:0] r_ostatus;
    logic [bfa_pkg::ADDR_W-1:0] r_ofaddr;
    logic [bfa_pkg::CNT_W-1:0]  r_ofree, r_oused;

    logic [18:0]                kb_frames;
    logic [FC_W-1:0]            fc, freec;
    logic                       req_fire, load_out, cfg_wr;
    logic                       ram_en, ram_we;
    logic [WA_W-1:0]            ram_addr;
    logic [bfa_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
    logic [bfa_pkg::WORD_W-1:0] mark_mask;
    logic [4:0]                 mask_lo, mask_hi;
    logic [32:0]                mark_sum;
    logic                       has_run, region_op;
    logic [FC_W-1:0]            mark_n, me_m1;
    bfa_pkg::t_scan_ctl         scan_ctl;
    bfa_pkg::t_scan_res         scan_res;
    logic [FR_W-1:0]            scan_start;
    logic [bfa_pkg::NIB_W-1:0]  scan_bits;

    // Frame count from memory size, limited to the bitmap size
    assign kb_frames = {r_kb, 1'b0} >> KB_SH;
    assign fc = (32'(kb_frames) > 32'(MAX_FRAMES)) ? FC_W'(MAX_FRAMES) : FC_W'(kb_frames);
    assign freec = (r_used >= fc) ? '0 : fc - r_used;

    assign req_fire = i_req.valid && i_req.ready;
    assign load_out = (r_state == bfa_pkg::ST_DONE) && (!r_ovalid || o_rsp.ready);
    assign region_op = (r_op == bfa_pkg::OP_RELEASE) || (r_op == bfa_pkg::OP_RESERVE);

    // Configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == bfa_pkg::REG_MEMORY_KB) ? 32'(r_kb) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kb <= bfa_pkg::KB_RESET;
        end else if (cfg_wr && paddr[2] == bfa_pkg::REG_MEMORY_KB) begin
            r_kb <= pwdata[bfa_pkg::KB_W-1:0];
        end
    end

    // Marking arithmetic
    assign mark_sum = {1'b0, r_ms} + {1'b0, r_mcount};
    assign has_run  = 32'(r_me) > r_ms;
    assign mark_n   = has_run ? r_me - FC_W'(r_ms) : '0;
    assign me_m1    = r_me - 1'b1;
    assign mask_lo  = (r_widx == r_wfirst) ? r_mlo : 5'd0;
    assign mask_hi  = (r_widx == r_wlast) ? r_mhi : 5'd31;
    assign mark_mask = ({bfa_pkg::WORD_W{1'b1}} << mask_lo)
                     & ({bfa_pkg::WORD_W{1'b1}} >> (5'd31 - mask_hi));

    assign scan_bits = bfa_pkg::NIB_W'(ram_rdata >> {r_nib, 2'b00});

    bfa_bitmap_ram #(.WORDS(WORDS), .AW(WA_W)) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    bfa_run_scan #(.FR_W(FR_W), .FC_W(FC_W)) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_bits  (scan_bits),
        .i_base  ({r_widx, r_nib, 2'b00}),
        .i_fc    (fc),
        .i_len   (r_len),
        .o_res   (scan_res),
        .o_start (scan_start)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfa_pkg::ST_CLEAR: begin
                if (r_widx == LAST_WORD) begin
                    n_state = r_resp ? bfa_pkg::ST_DONE : bfa_pkg::ST_IDLE;
                end
            end
            bfa_pkg::ST_IDLE: begin
                if (req_fire) begin
                    n_state = bfa_pkg::ST_DECODE;
                end
            end
            bfa_pkg::ST_DECODE: begin
                priority case (r_op)
                    bfa_pkg::OP_INIT: n_state = bfa_pkg::ST_CLEAR;
                    bfa_pkg::OP_ALLOC: begin
                        if (r_len == '0 || 32'(freec) < r_len) begin
                            n_state = bfa_pkg::ST_DONE;
                        end else begin
                            n_state = bfa_pkg::ST_SRD;
                        end
                    end
                    bfa_pkg::OP_FREE: begin
                        n_state = (r_len == '0) ? bfa_pkg::ST_DONE : bfa_pkg::ST_MSET;
                    end
                    bfa_pkg::OP_RELEASE, bfa_pkg::OP_RESERVE: n_state = bfa_pkg::ST_MSET;
                    default: n_state = bfa_pkg::ST_DONE;
                endcase
            end
            bfa_pkg::ST_SRD: n_state = bfa_pkg::ST_SSCAN;
            bfa_pkg::ST_SSCAN: begin
                if (scan_res.found) begin
                    n_state = bfa_pkg::ST_MSET;
                end else if (scan_res.past_end) begin
                    n_state = bfa_pkg::ST_DONE;
                end else if (r_nib == 3'd7) begin
                    n_state = (r_widx == LAST_WORD) ? bfa_pkg::ST_DONE : bfa_pkg::ST_SRD;
                end
            end
            bfa_pkg::ST_MSET: n_state = bfa_pkg::ST_MCNT;
            bfa_pkg::ST_MCNT: begin
                if (has_run) begin
                    n_state = bfa_pkg::ST_MRD;
                end else if (region_op && fc != '0) begin
                    n_state = bfa_pkg::ST_ZRD;
                end else begin
                    n_state = bfa_pkg::ST_DONE;
                end
            end
            bfa_pkg::ST_MRD: n_state = bfa_pkg::ST_MWR;
            bfa_pkg::ST_MWR: begin
                if (r_widx != r_wlast) begin
                    n_state = bfa_pkg::ST_MRD;
                end else if (region_op && fc != '0) begin
                    n_state = bfa_pkg::ST_ZRD;
                end else begin
                    n_state = bfa_pkg::ST_DONE;
                end
            end
            bfa_pkg::ST_ZRD: n_state = bfa_pkg::ST_ZWR;
            bfa_pkg::ST_ZWR: n_state = bfa_pkg::ST_DONE;
            bfa_pkg::ST_DONE: begin
                if (load_out) begin
                    n_state = bfa_pkg::ST_IDLE;
                end
            end
            default: n_state = bfa_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory and scanner control
    always_comb begin
        n_used   = r_used;
        n_widx   = r_widx;
        n_wfirst = r_wfirst;
        n_wlast  = r_wlast;
        n_nib    = r_nib;
        n_ms     = r_ms;
        n_mcount = r_mcount;
        n_me     = r_me;
        n_mlo    = r_mlo;
        n_mhi    = r_mhi;
        n_mval   = r_mval;
        n_status = r_status;
        n_faddr  = r_faddr;
        n_resp   = r_resp;
        n_ovalid = r_ovalid && !o_rsp.ready;
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = r_widx;
        ram_wdata = {bfa_pkg::WORD_W{1'b1}};
        scan_ctl = '0;
        i_req.ready = 1'b0;
        unique case (r_state)
            bfa_pkg::ST_CLEAR: begin
                ram_en = 1'b1;
                ram_we = 1'b1;
                n_widx = r_widx + 1'b1;
            end
            bfa_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                n_status = bfa_pkg::STAT_OK;
                n_faddr  = '0;
            end
            bfa_pkg::ST_DECODE: begin
                n_widx = '0;
                n_nib  = '0;
                scan_ctl.clear = 1'b1;
                priority case (r_op)
                    bfa_pkg::OP_INIT: begin
                        n_resp = 1'b1;
                        n_used = fc;
                    end
                    bfa_pkg::OP_ALLOC: begin
                        if (r_len == '0) begin
                            n_status = bfa_pkg::STAT_ZERO;
                        end else if (32'(freec) < r_len) begin
                            n_status = bfa_pkg::STAT_NO_ROOM;
                        end
                    end
                    bfa_pkg::OP_FREE: begin
                        n_status = (r_len == '0) ? bfa_pkg::STAT_ZERO : bfa_pkg::STAT_OK;
                        n_ms     = r_addr >> FB_LOG;
                        n_mcount = r_len;
                        n_mval   = 1'b0;
                    end
                    bfa_pkg::OP_RELEASE, bfa_pkg::OP_RESERVE: begin
                        n_ms     = r_addr >> FB_LOG;
                        n_mcount = r_len >> FB_LOG;
                        n_mval   = (r_op == bfa_pkg::OP_RESERVE);
                    end
                    default: n_status = bfa_pkg::STAT_OK;
                endcase
            end
            bfa_pkg::ST_SRD: begin
                ram_en = 1'b1;
            end
            bfa_pkg::ST_SSCAN: begin
                scan_ctl.step = 1'b1;
                n_nib = r_nib + 1'b1;
                if (scan_res.found) begin
                    n_ms     = 32'(scan_start);
                    n_mcount = r_len;
                    n_mval   = 1'b1;
                    n_faddr  = 32'(64'(scan_start) << FB_LOG);
                end else if (scan_res.past_end) begin
                    n_status = bfa_pkg::STAT_NO_ROOM;
                end else if (r_nib == 3'd7) begin
                    if (r_widx == LAST_WORD) begin
                        n_status = bfa_pkg::STAT_NO_ROOM;
                    end else begin
                        n_widx = r_widx + 1'b1;
                    end
                end
            end
            bfa_pkg::ST_MSET: begin
                n_me = (mark_sum > 33'(fc)) ? fc : FC_W'(mark_sum);
            end
            bfa_pkg::ST_MCNT: begin
                // Saturating count update by the frames in range
                if (r_mval) begin
                    if (r_used >= fc || mark_n >= fc - r_used) begin
                        n_used = fc;
                    end else begin
                        n_used = r_used + mark_n;
                    end
                end else begin
                    n_used = (mark_n >= r_used) ? '0 : r_used - mark_n;
                end
                n_widx   = r_ms[FR_W-1:5];
                n_wfirst = r_ms[FR_W-1:5];
                n_wlast  = me_m1[FR_W-1:5];
                n_mlo    = r_ms[4:0];
                n_mhi    = 5'(me_m1);
            end
            bfa_pkg::ST_MRD: begin
                ram_en = 1'b1;
            end
            bfa_pkg::ST_MWR: begin
                ram_en = 1'b1;
                ram_we = 1'b1;
                ram_wdata = r_mval ? (ram_rdata | mark_mask) : (ram_rdata & ~mark_mask);
                n_widx = r_widx + 1'b1;
            end
            bfa_pkg::ST_ZRD: begin
                ram_en   = 1'b1;
                ram_addr = '0;
            end
            bfa_pkg::ST_ZWR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = '0;
                ram_wdata = ram_rdata | bfa_pkg::WORD_W'(1);
            end
            bfa_pkg::ST_DONE: begin
                n_resp = 1'b0;
                if (load_out) begin
                    n_ovalid = 1'b1;
                end
            end
            default: n_resp = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bfa_pkg::ST_CLEAR;
            r_used   <= FC_W'(RESET_FC);
            r_widx   <= '0;
            r_nib    <= '0;
            r_resp   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_widx   <= n_widx;
            r_nib    <= n_nib;
            r_resp   <= n_resp;
            r_ovalid <= n_ovalid;
        end
    end

    // Request and working payload
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_op   <= i_req.opcode;
            r_addr <= i_req.address;
            r_len  <= i_req.length;
        end
        r_wfirst <= n_wfirst;
        r_wlast  <= n_wlast;
        r_ms     <= n_ms;
        r_mcount <= n_mcount;
        r_me     <= n_me;
        r_mlo    <= n_mlo;
        r_mhi    <= n_mhi;
        r_mval   <= n_mval;
        r_status <= n_status;
        r_faddr  <= n_faddr;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_ostatus <= r_status;
            r_ofaddr  <= r_faddr;
            r_ofree   <= bfa_pkg::CNT_W'(freec);
            r_oused   <= bfa_pkg::CNT_W'(r_used);
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.status        = r_ostatus;
    assign o_rsp.frame_address = r_ofaddr;
    assign o_rsp.free_frames   = r_ofree;
    assign o_rsp.used_frames   = r_oused;

    // Checks
    `BFA_ASSERT_IMP(a_ram_write_state, ram_we, (r_state == bfa_pkg::ST_CLEAR) || (r_state == bfa_pkg::ST_MWR) || (r_state == bfa_pkg::ST_ZWR))
    `BFA_ASSERT_NXT(a_request_starts_work, req_fire, r_state == bfa_pkg::ST_DECODE)
    `BFA_ASSERT_NXT(a_result_loaded, load_out, r_ovalid && r_state == bfa_pkg::ST_IDLE)
endmodule
`default_nettype wire

>>> design/bfa_bitmap_ram.sv
// Usage bitmap memory: one port, registered read data.
`default_nettype none
module bfa_bitmap_ram #(
    parameter int WORDS = 1024,
    parameter int AW    = 10
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_addr,
    input  wire logic [bfa_pkg::WORD_W-1:0] i_wdata,
    output logic [bfa_pkg::WORD_W-1:0]      o_rdata
);
    logic [bfa_pkg::WORD_W-1:0] r_mem [WORDS];
    logic [bfa_pkg::WORD_W-1:0] r_rdata;

    // Write or read one word per cycle
    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_en && !i_we) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> design/bfa_run_scan.sv
// First-fit run tracker: walks four bitmap bits a step.
`default_nettype none
module bfa_run_scan #(
    parameter int FR_W = 15,
    parameter int FC_W = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bfa_pkg::t_scan_ctl          i_ctl,
    input  wire logic [bfa_pkg::NIB_W-1:0]   i_bits,
    input  wire logic [FR_W-1:0]             i_base,
    input  wire logic [FC_W-1:0]             i_fc,
    input  wire logic [bfa_pkg::LEN_W-1:0]   i_len,
    output bfa_pkg::t_scan_res               o_res,
    output logic [FR_W-1:0]                  o_start
);
    logic [FC_W-1:0] r_run, n_run;
    logic [FR_W-1:0] r_start, n_start;
    logic            found, past_end;

    // Advance the free run over the four frames of this step
    always_comb begin
        logic [FR_W-1:0] f;
        n_run    = r_run;
        n_start  = r_start;
        found    = 1'b0;
        past_end = 1'b0;
        f        = '0;
        for (int k = 0; k < bfa_pkg::NIB_W; k++) begin
            f = i_base + FR_W'(k);
            if (!found && !past_end) begin
                if (32'(f) >= 32'(i_fc)) begin
                    past_end = 1'b1;
                end else if (i_bits[k]) begin
                    n_run = '0;
                end else begin
                    if (n_run == '0) begin
                        n_start = f;
                    end
                    n_run = n_run + 1'b1;
                    if (32'(n_run) == i_len) begin
                        found = 1'b1;
                    end
                end
            end
        end
    end

    // Hold run length and start between steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_run   <= '0;
            r_start <= '0;
        end else if (i_ctl.step) begin
            r_run   <= n_run;
            r_start <= n_start;
        end
    end

    assign o_res.found    = found;
    assign o_res.past_end = past_end;
    assign o_start        = n_start;
endmodule
`default_nettype wire

>>> sim/tb_bitmap_frame_allocator.sv
// Testbench of the bitmap frame allocator: directed and random requests checked against a predictor.
`default_nettype none
module tb_bitmap_frame_allocator;
    localparam int MAX_FR    = 32768;
    localparam int FR_BYTES  = 4096;
    localparam int CYC_LIMIT = 20000000;

    typedef struct packed {
        logic [bfa_pkg::STAT_W-1:0] status;
        logic [bfa_pkg::ADDR_W-1:0] frame_address;
        logic [bfa_pkg::CNT_W-1:0]  free_frames;
        logic [bfa_pkg::CNT_W-1:0]  used_frames;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [bfa_pkg::APB_AW-1:0] paddr;
    logic [bfa_pkg::APB_DW-1:0] pwdata;
    logic [bfa_pkg::APB_DW-1:0] prdata;
    logic pready;

    bfa_req_if req_ch();
    bfa_rsp_if rsp_ch();

    bitmap_frame_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: usage bitmap, used count and memory size
    bit                        usage_map [MAX_FR];
    int unsigned               used_cnt;
    logic [bfa_pkg::KB_W-1:0]  mem_kb;

    t_result     pending_results [$];
    int unsigned mismatches;
    int unsigned cycles;
    bit          quiet;

    always #4 i_clk = ~i_clk;

    // Frame count given by the memory size, capped at the bitmap size
    function automatic int unsigned frame_total();
        longint unsigned n;
        begin
            n = (longint'(mem_kb) * 1024) / FR_BYTES;
            if (n > MAX_FR)
                n = MAX_FR;
            return int'(n);
        end
    endfunction

    // Mark frames of a run that lie below the frame count; return how many
    function automatic int unsigned mark_frames(longint unsigned start, longint unsigned cnt,
                                                bit val);
        longint unsigned stop;
        int unsigned touched;
        begin
            touched = 0;
            stop = start + cnt;
            if (stop > frame_total())
                stop = frame_total();
            for (longint unsigned f = start; f < stop; f++) begin
                usage_map[f] = val;
                touched++;
            end
            return touched;
        end
    endfunction

    function automatic void used_add(int unsigned n);
        int unsigned fc;
        begin
            fc = frame_total();
            if (used_cnt >= fc || n >= fc - used_cnt)
                used_cnt = fc;
            else
                used_cnt += n;
        end
    endfunction

    function automatic void used_sub(int unsigned n);
        used_cnt = (n >= used_cnt) ? 0 : used_cnt - n;
    endfunction

    // Apply one request to the predictor and return the result it gives
    function automatic t_result allocator_outcome(logic [bfa_pkg::OPC_W-1:0] op,
                                                  logic [bfa_pkg::ADDR_W-1:0] addr,
                                                  logic [bfa_pkg::LEN_W-1:0] len);
        t_result r;
        int unsigned fc;
        int unsigned freec;
        int unsigned n;
        int unsigned run;
        int unsigned start;
        bit found;
        begin
            r = '0;
            r.status = bfa_pkg::STAT_OK;
            fc = frame_total();
            case (op)
                bfa_pkg::OP_INIT: begin
                    foreach (usage_map[i]) usage_map[i] = 1'b1;
                    used_cnt = fc;
                end
                bfa_pkg::OP_ALLOC: begin
                    freec = (used_cnt >= fc) ? 0 : fc - used_cnt;
                    if (len == 0) begin
                        r.status = bfa_pkg::STAT_ZERO;
                    end else if (longint'(freec) < longint'(len)) begin
                        r.status = bfa_pkg::STAT_NO_ROOM;
                    end else begin
                        run = 0;
                        start = 0;
                        found = 0;
                        for (int unsigned f = 0; f < fc && !found; f++) begin
                            if (usage_map[f]) begin
                                run = 0;
                            end else begin
                                if (run == 0)
                                    start = f;
                                run++;
                                if (run == len)
                                    found = 1;
                            end
                        end
                        if (!found) begin
                            r.status = bfa_pkg::STAT_NO_ROOM;
                        end else begin
                            used_add(mark_frames(start, len, 1'b1));
                            r.frame_address = start * FR_BYTES;
                        end
                    end
                end
                bfa_pkg::OP_FREE: begin
                    if (len == 0)
                        r.status = bfa_pkg::STAT_ZERO;
                    else
                        used_sub(mark_frames(addr / FR_BYTES, len, 1'b0));
                end
                bfa_pkg::OP_RELEASE, bfa_pkg::OP_RESERVE: begin
                    n = mark_frames(addr / FR_BYTES, len / FR_BYTES,
                                    op == bfa_pkg::OP_RESERVE);
                    if (op == bfa_pkg::OP_RESERVE)
                        used_add(n);
                    else
                        used_sub(n);
                    if (fc > 0)
                        usage_map[0] = 1'b1;
                end
                default: ;
            endcase
            fc = frame_total();
            r.free_frames = (used_cnt >= fc) ? '0 : bfa_pkg::CNT_W'(fc - used_cnt);
            r.used_frames = bfa_pkg::CNT_W'(used_cnt);
            return r;
        end
    endfunction

    function automatic void flag_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
        if (mismatches < 10)
            $display("mismatch %s: expected %0h, got %0h", what, exp_v, act_v);
        mismatches++;
    endfunction

    // Compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result", 0, rsp_ch.status);
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                    flag_mismatch("status", want.status, rsp_ch.status);
                if (rsp_ch.frame_address !== want.frame_address)
                    flag_mismatch("frame_address", want.frame_address, rsp_ch.frame_address);
                if (rsp_ch.free_frames !== want.free_frames)
                    flag_mismatch("free_frames", want.free_frames, rsp_ch.free_frames);
                if (rsp_ch.used_frames !== want.used_frames)
                    flag_mismatch("used_frames", want.used_frames, rsp_ch.used_frames);
            end
        end
    end

    // End the run if it hangs
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stall the result side in random bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (quiet || $urandom_range(0, 3) != 0) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge i_clk);
            end
        end
    end

    // Send one request, with an optional idle burst ahead of it
    task automatic send_request(logic [bfa_pkg::OPC_W-1:0] op,
                                logic [bfa_pkg::ADDR_W-1:0] addr,
                                logic [bfa_pkg::LEN_W-1:0] len);
        int unsigned gap;
        begin
            gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
            @(negedge i_clk);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            req_ch.valid   <= 1'b1;
            req_ch.opcode  <= op;
            req_ch.address <= addr;
            req_ch.length  <= len;
            @(posedge i_clk);
            while (!req_ch.ready) @(posedge i_clk);
            pending_results.push_back(allocator_outcome(op, addr, len));
        end
    endtask

    // Hold the sender until every expected result has come
    task automatic drain();
        begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            wait (pending_results.size() == 0);
            repeat (20) @(posedge i_clk);
        end
    endtask

    // Write memory_kb while idle, then read it back
    task automatic set_memory_kb(logic [bfa_pkg::KB_W-1:0] kb);
        begin
            drain();
            @(negedge i_clk);
            psel    <= 1'b1;
            pwrite  <= 1'b1;
            paddr   <= '0;
            pwdata  <= bfa_pkg::APB_DW'(kb);
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            mem_kb = kb;
            @(negedge i_clk);
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            if (prdata !== bfa_pkg::APB_DW'(kb))
                flag_mismatch("memory_kb read", kb, prdata);
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Random request, mostly well formed for the current frame count
    task automatic random_request();
        int unsigned fc;
        int unsigned pick;
        logic [bfa_pkg::ADDR_W-1:0] addr;
        logic [bfa_pkg::LEN_W-1:0] len;
        logic [bfa_pkg::OPC_W-1:0] op;
        begin
            fc = frame_total();
            pick = $urandom_range(0, 99);
            addr = ($urandom_range(0, fc + 3) * FR_BYTES) + $urandom_range(0, FR_BYTES - 1);
            if (pick < 8) begin
                op = bfa_pkg::OPC_W'($urandom_range(0, 7));
                addr = $urandom;
                len = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 4095);
                if (op == bfa_pkg::OP_ALLOC && len > 64)
                    len = $urandom;
            end else if (pick < 11) begin
                op = bfa_pkg::OP_INIT;
                len = $urandom;
            end else if (pick < 14) begin
                op = bfa_pkg::OPC_W'($urandom_range(5, 7));
                len = $urandom;
            end else if (pick < 50) begin
                op = bfa_pkg::OP_ALLOC;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, fc + 2)
                                                  : $urandom_range(1, 8);
            end else if (pick < 70) begin
                op = bfa_pkg::OP_FREE;
                len = $urandom_range(0, 10);
            end else begin
                op = ($urandom_range(0, 1) == 0) ? bfa_pkg::OP_RELEASE : bfa_pkg::OP_RESERVE;
                len = ($urandom_range(0, 12) * FR_BYTES) + $urandom_range(0, FR_BYTES - 1);
            end
            send_request(op, addr, len);
        end
    endtask

    // Zero counts and out-of-reset behaviour
    task automatic test_reset_state();
        begin
            send_request(bfa_pkg::OP_ALLOC, '0, 32'd1);
            send_request(bfa_pkg::OP_ALLOC, '0, '0);
            send_request(bfa_pkg::OP_FREE, '0, '0);
            send_request(bfa_pkg::OP_FREE, 32'hffff_ffff, 32'hffff_ffff);
        end
    endtask

    // Every operation on a small map, search failures and saturation
    task automatic test_directed_ops();
        begin
            set_memory_kb(18'd64);
            send_request(bfa_pkg::OP_INIT, '0, '0);
            send_request(bfa_pkg::OP_RELEASE, '0, 32'hffff_ffff);
            send_request(bfa_pkg::OP_ALLOC, '0, 32'd1);
            send_request(bfa_pkg::OP_ALLOC, '0, 32'd16);
            send_request(bfa_pkg::OP_RESERVE, 32'h0000_0fff, 32'h0001_0000);
            send_request(bfa_pkg::OP_RESERVE, '0, 32'h0001_0000);
            send_request(bfa_pkg::OP_RELEASE, 32'h0000_2000, 32'h0000_2fff);
            send_request(bfa_pkg::OP_RELEASE, 32'h0000_6000, 32'h0000_2000);
            send_request(bfa_pkg::OP_ALLOC, '0, 32'd3);
            send_request(bfa_pkg::OP_ALLOC, '0, 32'd2);
            send_request(bfa_pkg::OP_FREE, 32'h0000_1000, 32'd40);
            send_request(bfa_pkg::OP_FREE, 32'h0000_1000, 32'd40);
            send_request(bfa_pkg::OP_ALLOC, '0, 32'hffff_ffff);
            send_request(3'd5, 32'hffff_ffff, 32'hffff_ffff);
            send_request(3'd6, '0, '0);
            send_request(3'd7, 32'h1234_5678, 32'd1);
            send_request(bfa_pkg::OP_INIT, 32'hffff_ffff, 32'hffff_ffff);
        end
    endtask

    // Frame counts of zero and at the cap, including a shrink that keeps the map
    task automatic test_config_extremes();
        begin
            set_memory_kb(18'd0);
            send_request(bfa_pkg::OP_RESERVE, '0, 32'h0000_4000);
            send_request(bfa_pkg::OP_ALLOC, '0, 32'd1);
            send_request(bfa_pkg::OP_INIT, '0, '0);
            set_memory_kb(18'd3);
            send_request(bfa_pkg::OP_RELEASE, '0, 32'hffff_ffff);
            set_memory_kb(18'h3ffff);
            send_request(bfa_pkg::OP_INIT, '0, '0);
            send_request(bfa_pkg::OP_RELEASE, 32'h0000_1000, 32'h0010_0000);
            send_request(bfa_pkg::OP_ALLOC, '0, 32'd300);
            set_memory_kb(18'd32);
            send_request(bfa_pkg::OP_ALLOC, '0, 32'd2);
        end
    endtask

    // Random requests across several small memory sizes
    task automatic test_random_small();
        logic [bfa_pkg::KB_W-1:0] sizes [5];
        begin
            sizes = '{18'd4, 18'd28, 18'd256, 18'd1024, 18'd4096};
            foreach (sizes[s]) begin
                set_memory_kb(sizes[s]);
                send_request(bfa_pkg::OP_INIT, '0, '0);
                send_request(bfa_pkg::OP_RELEASE, '0, 32'hffff_ffff);
                for (int i = 0; i < 280; i++)
                    random_request();
            end
        end
    endtask

    // A short random run at the full memory size
    task automatic test_random_full();
        begin
            set_memory_kb(bfa_pkg::KB_RESET);
            send_request(bfa_pkg::OP_RELEASE, '0, 32'hffff_ffff);
            for (int i = 0; i < 100; i++)
                random_request();
        end
    endtask

    // Closing run with no idling on either side
    task automatic test_back_to_back();
        begin
            set_memory_kb(18'd256);
            quiet = 1'b1;
            for (int i = 0; i < 100; i++)
                random_request();
            drain();
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.opcode = bfa_pkg::OP_INIT;
        req_ch.address = '0;
        req_ch.length = '0;
        rsp_ch.ready = 1'b0;
        mismatches = 0;
        cycles = 0;
        quiet = 1'b0;
        mem_kb = bfa_pkg::KB_RESET;
        foreach (usage_map[i]) usage_map[i] = 1'b1;
        used_cnt = frame_total();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed_ops();
        test_config_extremes();
        test_random_small();
        test_random_full();
        test_back_to_back();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
